// File: rtl/assert_macros.svh
// assertion macros used by the allocator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant violated");
`define CHK_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");
`else
`define CHK_ALWAYS(lbl, clk, rst, expr)
`define CHK_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/ffea_pkg.sv
// types, codes and helpers of the first-fit extent allocator
package ffea_pkg;

   localparam logic [1:0] OP_INIT  = 2'd0;
   localparam logic [1:0] OP_ALLOC = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;
   localparam logic [1:0] OP_QUERY = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_NOSPACE = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam logic [7:0] CSR_POOL_BASE = 8'd0;
   localparam logic [7:0] CSR_POOL_SIZE = 8'd1;

   localparam logic [31:0] CHECK_VALUE = 32'h0fe39ace;
   localparam logic [31:0] HDR_BYTES   = 32'd16;
   localparam logic [32:0] MIN_CHUNK   = 33'd64;
   localparam logic [31:0] MIN_POOL    = 32'd128;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] request_size;
      logic [31:0] user_address;
      logic [31:0] stored_size;
      logic [31:0] header_check;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] result_address;
      logic [31:0] chunk_size;
      logic [31:0] check_word;
      logic [31:0] bytes_left;
   } rsp_type;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] length;
   } extent_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hffffffff : s[31:0];
   endfunction

   function automatic logic [32:0] end_of(input extent_type e);
      return {1'b0, e.start} + {1'b0, e.length};
   endfunction

endpackage

// File: rtl/ffea_ram.sv
// generic single write port ram with registered read
module ffea_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

// File: rtl/first_fit_extent_allocator_unit.sv
// top level: extent table sequencer of the first-fit allocator
//
//  channel  direction  handshake            payload
//  req_     in         req_valid/req_ready  ffea_pkg::req_type
//  rsp_     out        rsp_valid/rsp_ready  ffea_pkg::rsp_type
//  csr_     in         csr_valid/csr_ready  csr_index, csr_wdata
//
// init, query and rejected items go straight to the result.
// allocate: reads each extent in turn until one fits, moving later entries down if it empties.
// free: scans the extents below the chunk, then merges or inserts, moving entries as needed.
// all table traffic goes through one ram port pair.
// reset clears count, free bytes and handshakes; table contents need none.
// req_ready is low while an item is in work; a result not yet taken holds the last cycle.
module first_fit_extent_allocator_unit #(
   parameter int MAX_EXTENTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffea_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ffea_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [7:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
`include "assert_macros.svh"

   localparam int IW = $clog2(MAX_EXTENTS);
   localparam int CW = $clog2(MAX_EXTENTS + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EXTENTS);
   localparam logic [CW-1:0] CNT_ONE = CW'(1);

   typedef enum logic [3:0] {
      S_IDLE, S_A_RD, S_A_CHK, S_F_RD, S_F_CHK, S_F_PLACE,
      S_SH_RD, S_SH_WR, S_W_NODE, S_DONE
   } state_type;

   state_type            state_ff;
   logic [31:0]          pool_base_ff, pool_size_ff, free_ff;
   logic [CW-1:0]        count_ff, idx_ff, node_ff;
   logic [32:0]          need_ff;
   logic [31:0]          base_ff, hsize_ff;
   ffea_pkg::extent_type prev_ff, next_ff, node_ext_ff;
   logic                 next_valid_ff, sh_ins_ff;
   ffea_pkg::rsp_type    res_ff, rsp_ff;
   logic                 rsp_valid_ff;

   logic                 ram_we;
   logic [IW-1:0]        ram_waddr, ram_raddr;
   ffea_pkg::extent_type ram_wdata, ram_rdata;

   logic [32:0] pad_raw, pad_need;
   logic [31:0] alloc_left;
   logic        merge_hit, prev_hit;
   logic [31:0] node_len_merged;

   ffea_ram #(.WIDTH($bits(ffea_pkg::extent_type)), .DEPTH(MAX_EXTENTS)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // header padding, rounded up to 16 and at least 64
   assign pad_raw  = {1'b0, req_payload.request_size} + {1'b0, ffea_pkg::HDR_BYTES};
   assign pad_need = (pad_raw < ffea_pkg::MIN_CHUNK) ? ffea_pkg::MIN_CHUNK :
                     (pad_raw[3:0] != 4'd0) ? {pad_raw[32:4] + 29'd1, 4'd0} : pad_raw;

   assign alloc_left = ram_rdata.length - need_ff[31:0];
   assign prev_hit   = (idx_ff != '0) && (ffea_pkg::end_of(prev_ff) == {1'b0, base_ff});
   assign merge_hit  = next_valid_ff && (ffea_pkg::end_of(node_ext_ff) == {1'b0, next_ff.start});
   assign node_len_merged = merge_hit ? ffea_pkg::sat_add(node_ext_ff.length, next_ff.length)
                                      : node_ext_ff.length;

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_raddr = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_payload.op == ffea_pkg::OP_INIT &&
                pool_size_ff >= ffea_pkg::MIN_POOL) begin
               ram_we    = 1'b1;
               ram_wdata = '{start: pool_base_ff, length: pool_size_ff};
            end
         end
         S_A_RD: ram_raddr = idx_ff[IW-1:0];
         S_A_CHK: begin
            if (ram_rdata.length >= need_ff[31:0] && alloc_left != 32'd0) begin
               ram_we    = 1'b1;
               ram_waddr = idx_ff[IW-1:0];
               ram_wdata = '{start: ram_rdata.start + need_ff[31:0], length: alloc_left};
            end
         end
         S_F_RD: ram_raddr = idx_ff[IW-1:0];
         S_SH_RD: ram_raddr = sh_ins_ff ? IW'(idx_ff - CNT_ONE) : IW'(idx_ff + CNT_ONE);
         S_SH_WR: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff[IW-1:0];
            ram_wdata = ram_rdata;
         end
         S_W_NODE: begin
            ram_we    = 1'b1;
            ram_waddr = node_ff[IW-1:0];
            ram_wdata = '{start: node_ext_ff.start, length: node_len_merged};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pool_base_ff  <= '0;
         pool_size_ff  <= '0;
         free_ff       <= '0;
         count_ff      <= '0;
         res_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               ffea_pkg::CSR_POOL_BASE: pool_base_ff <= csr_wdata;
               ffea_pkg::CSR_POOL_SIZE: pool_size_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  idx_ff <= '0;
                  unique case (req_payload.op)
                     ffea_pkg::OP_INIT: begin
                        state_ff <= S_DONE;
                        if (pool_size_ff < ffea_pkg::MIN_POOL) begin
                           res_ff.status <= ffea_pkg::ST_INVALID;
                        end else begin
                           count_ff <= CNT_ONE;
                           free_ff  <= pool_size_ff;
                        end
                     end
                     ffea_pkg::OP_ALLOC: begin
                        need_ff <= pad_need;
                        if (req_payload.request_size == 32'd0) begin
                           res_ff.status <= ffea_pkg::ST_INVALID;
                           state_ff      <= S_DONE;
                        end else if (pad_need > {1'b0, free_ff}) begin
                           res_ff.status <= ffea_pkg::ST_NOSPACE;
                           state_ff      <= S_DONE;
                        end else begin
                           state_ff <= S_A_RD;
                        end
                     end
                     ffea_pkg::OP_FREE: begin
                        base_ff  <= req_payload.user_address - ffea_pkg::HDR_BYTES;
                        hsize_ff <= req_payload.stored_size;
                        if (req_payload.user_address == 32'd0 ||
                            req_payload.header_check != ffea_pkg::CHECK_VALUE ||
                            req_payload.stored_size == 32'd0) begin
                           res_ff.status <= ffea_pkg::ST_INVALID;
                           state_ff      <= S_DONE;
                        end else begin
                           state_ff <= S_F_RD;
                        end
                     end
                     ffea_pkg::OP_QUERY: begin
                        res_ff.bytes_left <= (free_ff >= ffea_pkg::HDR_BYTES) ?
                                             free_ff - ffea_pkg::HDR_BYTES : 32'd0;
                        state_ff          <= S_DONE;
                     end
                     default: ;
                  endcase
               end
            end
            S_A_RD: begin
               if (idx_ff == count_ff) begin
                  res_ff.status <= ffea_pkg::ST_NOSPACE;
                  state_ff      <= S_DONE;
               end else begin
                  state_ff <= S_A_CHK;
               end
            end
            S_A_CHK: begin
               if (ram_rdata.length >= need_ff[31:0]) begin
                  free_ff               <= free_ff - need_ff[31:0];
                  res_ff.result_address <= ram_rdata.start + ffea_pkg::HDR_BYTES;
                  res_ff.chunk_size     <= need_ff[31:0];
                  res_ff.check_word     <= ffea_pkg::CHECK_VALUE;
                  // emptied extent leaves the table
                  if (alloc_left == 32'd0 && idx_ff + CNT_ONE < count_ff) begin
                     sh_ins_ff <= 1'b0;
                     state_ff  <= S_SH_RD;
                  end else begin
                     if (alloc_left == 32'd0) begin
                        count_ff <= count_ff - CNT_ONE;
                     end
                     state_ff <= S_DONE;
                  end
               end else begin
                  idx_ff   <= idx_ff + CNT_ONE;
                  state_ff <= S_A_RD;
               end
            end
            S_F_RD: begin
               if (idx_ff == count_ff) begin
                  next_valid_ff <= 1'b0;
                  state_ff      <= S_F_PLACE;
               end else begin
                  state_ff <= S_F_CHK;
               end
            end
            S_F_CHK: begin
               if (ram_rdata.start < base_ff) begin
                  prev_ff  <= ram_rdata;
                  idx_ff   <= idx_ff + CNT_ONE;
                  state_ff <= S_F_RD;
               end else begin
                  next_ff       <= ram_rdata;
                  next_valid_ff <= 1'b1;
                  state_ff      <= S_F_PLACE;
               end
            end
            S_F_PLACE: begin
               if (prev_hit) begin
                  node_ff     <= idx_ff - CNT_ONE;
                  node_ext_ff <= '{start: prev_ff.start,
                                   length: ffea_pkg::sat_add(prev_ff.length, hsize_ff)};
                  state_ff    <= S_W_NODE;
               end else if (count_ff >= CNT_MAX) begin
                  res_ff.status <= ffea_pkg::ST_FULL;
                  state_ff      <= S_DONE;
               end else begin
                  // open a slot at the insert point, moving the tail up
                  node_ff     <= idx_ff;
                  node_ext_ff <= '{start: base_ff, length: hsize_ff};
                  count_ff    <= count_ff + CNT_ONE;
                  sh_ins_ff   <= 1'b1;
                  idx_ff      <= count_ff;
                  state_ff    <= (count_ff > idx_ff) ? S_SH_RD : S_W_NODE;
               end
            end
            S_SH_RD: state_ff <= S_SH_WR;
            S_SH_WR: begin
               if (sh_ins_ff) begin
                  idx_ff   <= idx_ff - CNT_ONE;
                  state_ff <= (idx_ff - CNT_ONE > node_ff) ? S_SH_RD : S_W_NODE;
               end else begin
                  idx_ff <= idx_ff + CNT_ONE;
                  if (idx_ff + CW'(2) < count_ff) begin
                     state_ff <= S_SH_RD;
                  end else begin
                     count_ff <= count_ff - CNT_ONE;
                     state_ff <= S_DONE;
                  end
               end
            end
            S_W_NODE: begin
               free_ff   <= ffea_pkg::sat_add(free_ff, hsize_ff);
               sh_ins_ff <= 1'b0;
               if (merge_hit && node_ff + CW'(2) < count_ff) begin
                  idx_ff   <= node_ff + CNT_ONE;
                  state_ff <= S_SH_RD;
               end else begin
                  if (merge_hit) begin
                     count_ff <= count_ff - CNT_ONE;
                  end
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff       <= res_ff;
                  res_ff       <= '0;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `CHK_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_MAX)
   `CHK_IMPLY(a_fail_no_chunk, clock, reset,
      rsp_valid_ff && rsp_ff.status != ffea_pkg::ST_OK,
      rsp_ff.chunk_size == 32'd0 && rsp_ff.result_address == 32'd0)
   `CHK_IMPLY(a_chunk_shape, clock, reset,
      rsp_valid_ff && rsp_ff.chunk_size != 32'd0,
      rsp_ff.chunk_size[3:0] == 4'd0 && rsp_ff.chunk_size >= 32'd64 &&
      rsp_ff.check_word == ffea_pkg::CHECK_VALUE)
   `CHK_IMPLY(a_scan_in_table, clock, reset,
      state_ff == S_A_CHK || state_ff == S_F_CHK, idx_ff < count_ff)

endmodule

// File: dv/first_fit_extent_allocator_unit_tb.sv
// testbench of the first-fit extent allocator: directed cases, table-full stress, random traffic
module first_fit_extent_allocator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 64;
   localparam longint CYCLE_LIMIT = 6_000_000;
   localparam logic [7:0] CSR_SPARE = 8'd7;

   typedef struct {
      logic [31:0] addr;
      logic [31:0] size;
   } chunk_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   ffea_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   ffea_pkg::rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [7:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   int send_idle_pct = 9;
   int recv_idle_pct = 83;
   int errors = 0;
   longint cycles = 0;

   // mirror of the allocator state
   logic [31:0] ext_base [TABLE_DEPTH];
   logic [31:0] ext_len [TABLE_DEPTH];
   int ext_count = 0;
   logic [31:0] pool_free = '0;
   logic [31:0] cfg_base = '0;
   logic [31:0] cfg_size = '0;

   ffea_pkg::rsp_type pending_rsp [$];
   chunk_rec_type live_chunks [$];

   first_fit_extent_allocator_unit #(.MAX_EXTENTS(TABLE_DEPTH)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] add_clamped(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hffffffff : s[31:0];
   endfunction

   function automatic void drop_extent(int i);
      for (int k = i; k + 1 < ext_count; k++) begin
         ext_base[k] = ext_base[k + 1];
         ext_len[k] = ext_len[k + 1];
      end
      ext_count--;
   endfunction

   function automatic ffea_pkg::rsp_type allocator_result(ffea_pkg::req_type r);
      ffea_pkg::rsp_type o;
      logic [33:0] need;
      logic [31:0] hdr, base;
      int i, p, node;
      o = '0;
      case (r.op)
         ffea_pkg::OP_INIT: begin
            if (cfg_size < ffea_pkg::MIN_POOL) o.status = ffea_pkg::ST_INVALID;
            else begin
               ext_base[0] = cfg_base;
               ext_len[0] = cfg_size;
               ext_count = 1;
               pool_free = cfg_size;
            end
         end
         ffea_pkg::OP_ALLOC: begin
            need = {2'b0, r.request_size} + 34'd16;
            if (r.request_size == 0) o.status = ffea_pkg::ST_INVALID;
            else begin
               if (need < 34'd64) need = 34'd64;
               else if (need[3:0] != 0) need = need + 34'd16 - need[3:0];
               if (need > {2'b0, pool_free}) o.status = ffea_pkg::ST_NOSPACE;
               else begin
                  i = 0;
                  while (i < ext_count && ext_len[i] < need[31:0]) i++;
                  if (i >= ext_count) o.status = ffea_pkg::ST_NOSPACE;
                  else begin
                     hdr = ext_base[i];
                     ext_base[i] = hdr + need[31:0];
                     ext_len[i] = ext_len[i] - need[31:0];
                     if (ext_len[i] == 0) drop_extent(i);
                     pool_free = pool_free - need[31:0];
                     o.status = ffea_pkg::ST_OK;
                     o.result_address = hdr + ffea_pkg::HDR_BYTES;
                     o.chunk_size = need[31:0];
                     o.check_word = ffea_pkg::CHECK_VALUE;
                  end
               end
            end
         end
         ffea_pkg::OP_FREE: begin
            if (r.user_address == 0 || r.header_check != ffea_pkg::CHECK_VALUE ||
                r.stored_size == 0)
               o.status = ffea_pkg::ST_INVALID;
            else begin
               base = r.user_address - ffea_pkg::HDR_BYTES;
               p = 0;
               while (p < ext_count && ext_base[p] < base) p++;
               if (p > 0 && {1'b0, ext_base[p-1]} + {1'b0, ext_len[p-1]} == {1'b0, base}) begin
                  node = p - 1;
                  ext_len[node] = add_clamped(ext_len[node], r.stored_size);
               end else if (ext_count >= TABLE_DEPTH) begin
                  o.status = ffea_pkg::ST_FULL;
                  return o;
               end else begin
                  for (int k = ext_count; k > p; k--) begin
                     ext_base[k] = ext_base[k - 1];
                     ext_len[k] = ext_len[k - 1];
                  end
                  ext_base[p] = base;
                  ext_len[p] = r.stored_size;
                  ext_count++;
                  node = p;
               end
               if (node + 1 < ext_count &&
                   {1'b0, ext_base[node]} + {1'b0, ext_len[node]} == {1'b0, ext_base[node+1]}) begin
                  ext_len[node] = add_clamped(ext_len[node], ext_len[node + 1]);
                  drop_extent(node + 1);
               end
               pool_free = add_clamped(pool_free, r.stored_size);
            end
         end
         default: o.bytes_left = (pool_free >= ffea_pkg::HDR_BYTES) ?
                                 pool_free - ffea_pkg::HDR_BYTES : 32'd0;
      endcase
      return o;
   endfunction

   // send one item, wait for its acceptance, record what the block owes
   task automatic issue(logic [1:0] op, logic [31:0] req_size, logic [31:0] uaddr,
                        logic [31:0] hsize, logic [31:0] hcheck);
      ffea_pkg::req_type r;
      ffea_pkg::rsp_type o;
      r = '{op: op, request_size: req_size, user_address: uaddr,
            stored_size: hsize, header_check: hcheck};
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      o = allocator_result(r);
      pending_rsp.push_back(o);
      if (op == ffea_pkg::OP_ALLOC && o.status == ffea_pkg::ST_OK) begin
         live_chunks.push_back('{o.result_address, o.chunk_size});
      end
      if (op == ffea_pkg::OP_INIT && o.status == ffea_pkg::ST_OK) live_chunks.delete();
   endtask

   task automatic wait_drained();
      if (req_valid) req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [7:0] idx, logic [31:0] data);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == ffea_pkg::CSR_POOL_BASE) cfg_base = data;
      else if (idx == ffea_pkg::CSR_POOL_SIZE) cfg_size = data;
   endtask

   task automatic free_live(int i);
      issue(ffea_pkg::OP_FREE, $urandom, live_chunks[i].addr, live_chunks[i].size,
            ffea_pkg::CHECK_VALUE);
      live_chunks.delete(i);
   endtask

   task automatic test_directed();
      // no init yet: empty table
      issue(ffea_pkg::OP_QUERY, 0, 0, 0, 0);
      issue(ffea_pkg::OP_ALLOC, 32'd100, 0, 0, 0);
      issue(ffea_pkg::OP_ALLOC, 32'd0, 0, 0, 0);
      issue(ffea_pkg::OP_INIT, 0, 0, 0, 0);
      write_reg(ffea_pkg::CSR_POOL_BASE, 32'h0000_1000);
      write_reg(ffea_pkg::CSR_POOL_SIZE, 32'd127);
      write_reg(CSR_SPARE, 32'hdead_beef);
      issue(ffea_pkg::OP_INIT, 0, 0, 0, 0);
      write_reg(ffea_pkg::CSR_POOL_SIZE, 32'd128);
      issue(ffea_pkg::OP_INIT, 0, 0, 0, 0);
      issue(ffea_pkg::OP_ALLOC, 32'd112, 0, 0, 0);
      issue(ffea_pkg::OP_QUERY, 0, 0, 0, 0);
      // bad frees
      issue(ffea_pkg::OP_FREE, 0, 32'd0, 32'd128, ffea_pkg::CHECK_VALUE);
      issue(ffea_pkg::OP_FREE, 0, 32'h1010, 32'd128, ~ffea_pkg::CHECK_VALUE);
      issue(ffea_pkg::OP_FREE, 0, 32'h1010, 32'd0, ffea_pkg::CHECK_VALUE);
      issue(ffea_pkg::OP_FREE, 0, 32'h1010, 32'd5, ffea_pkg::CHECK_VALUE);
      issue(ffea_pkg::OP_QUERY, 0, 0, 0, 0);
      // no single extent fits although enough bytes are free
      write_reg(ffea_pkg::CSR_POOL_SIZE, 32'd256);
      issue(ffea_pkg::OP_INIT, 0, 0, 0, 0);
      repeat (4) issue(ffea_pkg::OP_ALLOC, 32'd1, 0, 0, 0);
      free_live(2);
      free_live(0);
      issue(ffea_pkg::OP_ALLOC, 32'd100, 0, 0, 0);
      issue(ffea_pkg::OP_ALLOC, 32'hffff_ffff, 0, 0, 0);
      // header start wraps past the top of the address space
      write_reg(ffea_pkg::CSR_POOL_BASE, 32'hffff_fff0);
      issue(ffea_pkg::OP_INIT, 0, 0, 0, 0);
      issue(ffea_pkg::OP_ALLOC, 32'd49, 0, 0, 0);
      issue(ffea_pkg::OP_ALLOC, 32'd48, 0, 0, 0);
      // saturation of free bytes and merged lengths
      write_reg(ffea_pkg::CSR_POOL_BASE, 32'd0);
      write_reg(ffea_pkg::CSR_POOL_SIZE, 32'hffff_ffff);
      issue(ffea_pkg::OP_INIT, 0, 0, 0, 0);
      issue(ffea_pkg::OP_FREE, 0, 32'h0000_000f, 32'h0000_0100, ffea_pkg::CHECK_VALUE);
      issue(ffea_pkg::OP_QUERY, 0, 0, 0, 0);
   endtask

   task automatic test_table_full();
      write_reg(ffea_pkg::CSR_POOL_BASE, 32'h0002_0000);
      write_reg(ffea_pkg::CSR_POOL_SIZE, 32'd9000);
      issue(ffea_pkg::OP_INIT, 0, 0, 0, 0);
      repeat (136) issue(ffea_pkg::OP_ALLOC, 32'd48, 0, 0, 0);
      // every other chunk: isolated extents until the table overflows
      for (int i = 0; i < 67; i++) free_live(i);
      free_live(0);
      issue(ffea_pkg::OP_QUERY, 0, 0, 0, 0);
   endtask

   task automatic test_random(int n);
      int pick;
      logic [31:0] sz;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 3) begin
            case ($urandom_range(5))
               0: sz = 32'd127;
               1: sz = 32'd128;
               2: sz = 32'hffff_ffff;
               3: sz = $urandom;
               default: sz = $urandom_range(128, 6000);
            endcase
            write_reg(ffea_pkg::CSR_POOL_BASE,
                      $urandom_range(1) ? $urandom : ($urandom & 32'hffff_fff0));
            write_reg(ffea_pkg::CSR_POOL_SIZE, sz);
            issue(ffea_pkg::OP_INIT, 0, 0, 0, 0);
         end else if (pick < 6) begin
            issue(ffea_pkg::OP_INIT, $urandom, $urandom, $urandom, $urandom);
         end else if (pick < 40) begin
            case ($urandom_range(19))
               0: sz = 32'd0;
               1: sz = $urandom;
               default: sz = $urandom_range(1, 400);
            endcase
            issue(ffea_pkg::OP_ALLOC, sz, $urandom, $urandom, $urandom);
         end else if (pick < 75) begin
            if (live_chunks.size() != 0) free_live($urandom_range(live_chunks.size() - 1));
            else issue(ffea_pkg::OP_ALLOC, $urandom_range(1, 300), 0, 0, 0);
         end else if (pick < 85) begin
            issue(ffea_pkg::OP_QUERY, $urandom, $urandom, $urandom, $urandom);
         end else begin
            // malformed or stray frees
            case ($urandom_range(3))
               0: issue(ffea_pkg::OP_FREE, $urandom, $urandom, $urandom, $urandom);
               1: issue(ffea_pkg::OP_FREE, $urandom, 32'd0, $urandom, ffea_pkg::CHECK_VALUE);
               2: issue(ffea_pkg::OP_FREE, $urandom, $urandom, 32'd0, ffea_pkg::CHECK_VALUE);
               default: issue(ffea_pkg::OP_FREE, $urandom, $urandom, $urandom_range(1, 256),
                              ffea_pkg::CHECK_VALUE);
            endcase
         end
      end
   endtask

   always @(posedge clock) begin
      ffea_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("result item with none expected");
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
               errors++;
            end
            if (rsp_payload.result_address !== want.result_address) begin
               $error("result_address: expected %h, got %h", want.result_address,
                      rsp_payload.result_address);
               errors++;
            end
            if (rsp_payload.chunk_size !== want.chunk_size) begin
               $error("chunk_size: expected %h, got %h", want.chunk_size, rsp_payload.chunk_size);
               errors++;
            end
            if (rsp_payload.check_word !== want.check_word) begin
               $error("check_word: expected %h, got %h", want.check_word, rsp_payload.check_word);
               errors++;
            end
            if (rsp_payload.bytes_left !== want.bytes_left) begin
               $error("bytes_left: expected %h, got %h", want.bytes_left, rsp_payload.bytes_left);
               errors++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_table_full();
      test_random(340);
      wait_drained();
      send_idle_pct = 83;
      recv_idle_pct = 9;
      test_random(340);
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(340);
      wait_drained();
      repeat (500) @(posedge clock);
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule

// File: files.f
+incdir+rtl
rtl/ffea_pkg.sv
rtl/ffea_ram.sv
rtl/first_fit_extent_allocator_unit.sv
dv/first_fit_extent_allocator_unit_tb.sv
